### sv/cfet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfet_pkg
// Shared types and constants of the color fade envelope table.
// ----------------------------------------------------------------------------
package cfet_pkg;

    localparam int SLOTS_DEF = 8;

    // entry phases
    localparam logic [1:0] PH_WAIT_IN  = 2'd0;
    localparam logic [1:0] PH_RAMP_IN  = 2'd1;
    localparam logic [1:0] PH_WAIT_OUT = 2'd2;
    localparam logic [1:0] PH_RAMP_OUT = 2'd3;

    // result status codes
    localparam logic [1:0] ST_UPDATE = 2'd0;
    localparam logic [1:0] ST_ADDED  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // register index
    localparam logic REG_BASE_COLOR = 1'b0;

    typedef struct packed {
        logic [2:0]  part;
        logic        mode;
        logic [31:0] target;
        logic [15:0] in_wait;
        logic [15:0] in_ramp;
        logic [15:0] out_wait;
        logic [15:0] out_ramp;
        logic [1:0]  phase;
        logic [15:0] acc;
        logic [15:0] aidx;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  part;
        logic [31:0] color;
        logic        retired;
    } t_res;

endpackage

### sv/cfet_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfet_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfet_mem
    import cfet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [IW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cfet_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfet_div
// Four-lane restoring divider, one quotient bit per lane per cycle.
// The quotient is known to fit in 8 bits (numerator below den * 256).
// ----------------------------------------------------------------------------
module cfet_div
    import cfet_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num [4],
    input  logic [15:0] i_den,
    output logic [7:0]  o_q [4],
    output logic        o_done
);

    logic [15:0] r_rem [4];
    logic [7:0]  r_low [4];
    logic [7:0]  r_q   [4];
    logic [15:0] r_den;
    logic [3:0]  r_cnt;
    logic        r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == 4'd1);
            if (i_start) begin
                r_cnt <= 4'd8;
            end else if (r_cnt != 4'd0) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    // lanes
    always_ff @(posedge i_clk) begin
        logic [16:0] t;
        if (i_start) begin
            r_den <= i_den;
        end
        for (int k = 0; k < 4; k++) begin
            t = {r_rem[k], r_low[k][7]};
            if (i_start) begin
                r_rem[k] <= i_num[k][23:8];
                r_low[k] <= i_num[k][7:0];
                r_q[k]   <= 8'd0;
            end else if (r_cnt != 4'd0) begin
                if (t >= {1'b0, r_den}) begin
                    r_rem[k] <= 16'(t - {1'b0, r_den});
                    r_q[k]   <= {r_q[k][6:0], 1'b1};
                end else begin
                    r_rem[k] <= t[15:0];
                    r_q[k]   <= {r_q[k][6:0], 1'b0};
                end
                r_low[k] <= {r_low[k][6:0], 1'b0};
            end
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

### sv/color_fade_envelope_table.sv
`timescale 1ns / 1ps
// Flow: an add's status word goes through the emit and flush states to the output; a tick
// reads and evaluates each entry, then skips it in wait-out, emits it plainly, or blends
// (multiply, 8-step divide) before emitting, and flushes the last word at the end.
// Throughput: one item at a time, each taken only in idle; output stalls hold emit and
// flush; the entry store's single read port and the shared divider pace each tick.
// Reset: synchronous, active low; clears entry count, base color, sequencer and output control only.
// ----------------------------------------------------------------------------
// color_fade_envelope_table
// Fade envelope table: entries in a memory, read, updated and written back
// in compacted order on every tick.
// ----------------------------------------------------------------------------
module color_fade_envelope_table
    import cfet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [2:0]  i_part,
    input  logic        i_mode,
    input  logic [31:0] i_target_color,
    input  logic [15:0] i_in_wait,
    input  logic [15:0] i_in_ramp,
    input  logic [15:0] i_out_wait,
    input  logic [15:0] i_out_ramp,
    input  logic [15:0] i_delta_time,
    input  logic [15:0] i_anim_index,
    input  logic [15:0] i_anim_frame,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_out_part,
    output logic [31:0] o_color,
    output logic        o_retired,
    output logic        o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EV    = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count, r_i, r_keep;
    logic          r_is_add;
    logic [31:0]   r_base;
    logic [15:0]   r_dt, r_aidx, r_afrm;
    t_res          r_res;
    t_res          r_hold;
    logic          r_h_valid;
    t_res          r_out;
    logic          r_out_last;
    logic          r_ov;
    // blend operands
    logic [31:0]   r_ca, r_cb;
    logic [15:0]   r_bacc, r_bramp;
    logic [23:0]   r_num [4];
    logic [3:0]    r_neg;
    logic          r_div_go;

    logic          in_acc, out_free, cfg_wr, out_load;
    t_entry        rdata, e_new;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          div_start, div_done;
    logic [7:0]    div_q [4];
    logic [16:0]   acc_sum;
    logic [15:0]   acc_sat, pos;
    logic [CW-1:0] i_nxt;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_BASE_COLOR) ? r_base : 32'd0;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_ov || !i_out_stall;
    assign out_load = r_h_valid && out_free &&
                      ((r_state == S_EMIT) || (r_state == S_FLUSH));
    assign i_nxt    = r_i + 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (cfg_wr && paddr[2] == REG_BASE_COLOR) begin
            r_base <= pwdata;
        end
    end

    cfet_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (rdata)
    );

    cfet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_bramp),
        .o_q     (div_q),
        .o_done  (div_done)
    );

    // start in the cycle after the products are registered
    assign div_start = r_div_go;

    // per-entry update of the word just read
    assign acc_sum = {1'b0, rdata.acc} + {1'b0, r_dt};
    assign acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
    assign pos     = rdata.mode ? r_afrm : acc_sat;

    always_comb begin
        e_new     = rdata;
        e_new.acc = acc_sat;
        case (rdata.phase)
            PH_WAIT_IN: begin
                if (pos >= rdata.in_wait) begin
                    e_new.acc   = 16'd0;
                    e_new.phase = PH_RAMP_IN;
                end
            end
            PH_RAMP_IN: begin
                if (acc_sat >= rdata.in_ramp) begin
                    e_new.acc   = 16'd0;
                    e_new.phase = PH_WAIT_OUT;
                end
            end
            PH_WAIT_OUT: begin
                if (pos >= rdata.out_wait) begin
                    e_new.acc   = 16'd0;
                    e_new.phase = PH_RAMP_OUT;
                end
            end
            default: begin
            end
        endcase
    end

    // memory write: add appends, tick writes back survivors compacted
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_keep[IW-1:0];
        mem_wdata = e_new;
        if (r_state == S_IDLE) begin
            mem_waddr = r_count[IW-1:0];
            mem_wdata.part     = i_part;
            mem_wdata.mode     = i_mode;
            mem_wdata.target   = i_target_color;
            mem_wdata.in_wait  = i_in_wait;
            mem_wdata.in_ramp  = i_in_ramp;
            mem_wdata.out_wait = i_out_wait;
            mem_wdata.out_ramp = i_out_ramp;
            mem_wdata.phase    = PH_WAIT_IN;
            mem_wdata.acc      = 16'd0;
            mem_wdata.aidx     = i_anim_index;
            mem_we = in_acc && i_kind && (r_count < CW'(SLOTS));
        end else if (r_state == S_EV) begin
            mem_we = !(rdata.mode && r_aidx != rdata.aidx) &&
                     !(rdata.phase == PH_RAMP_OUT && acc_sat >= rdata.out_ramp);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        logic [8:0] d;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_i       <= '0;
            r_keep    <= '0;
            r_is_add  <= 1'b0;
            r_h_valid <= 1'b0;
            r_ov      <= 1'b0;
            r_div_go  <= 1'b0;
        end else begin
            r_ov     <= out_load || (r_ov && i_out_stall);
            r_div_go <= (r_state == S_MUL);
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_dt   <= i_delta_time;
                        r_aidx <= i_anim_index;
                        r_afrm <= i_anim_frame;
                        r_i    <= '0;
                        r_keep <= '0;
                        r_is_add <= i_kind;
                        if (i_kind) begin
                            r_res.part    <= i_part;
                            r_res.color   <= 32'd0;
                            r_res.retired <= 1'b0;
                            if (r_count < CW'(SLOTS)) begin
                                r_res.status <= ST_ADDED;
                                r_count      <= r_count + 1'b1;
                            end else begin
                                r_res.status <= ST_FULL;
                            end
                            r_state <= S_EMIT;
                        end else if (r_count == '0) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (mem_we) begin
                        r_keep <= r_keep + 1'b1;
                    end
                    r_res.status <= ST_UPDATE;
                    r_res.part   <= rdata.part;
                    r_bacc       <= acc_sat;
                    if (rdata.mode && r_aidx != rdata.aidx) begin
                        r_res.color   <= r_base;
                        r_res.retired <= 1'b1;
                        r_state       <= S_EMIT;
                    end else begin
                        case (rdata.phase)
                            PH_WAIT_IN: begin
                                r_res.color   <= r_base;
                                r_res.retired <= 1'b0;
                                r_state       <= S_EMIT;
                            end
                            PH_RAMP_IN: begin
                                r_res.retired <= 1'b0;
                                if (acc_sat >= rdata.in_ramp) begin
                                    r_res.color <= rdata.target;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_ca    <= r_base;
                                    r_cb    <= rdata.target;
                                    r_bramp <= rdata.in_ramp;
                                    r_state <= S_MUL;
                                end
                            end
                            PH_WAIT_OUT: begin
                                // no update; move on
                                r_i <= i_nxt;
                                if (i_nxt == r_count) begin
                                    r_count <= mem_we ? r_keep + 1'b1 : r_keep;
                                    r_state <= S_FLUSH;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (acc_sat >= rdata.out_ramp) begin
                                    r_res.color   <= r_base;
                                    r_res.retired <= 1'b1;
                                    r_state       <= S_EMIT;
                                end else begin
                                    r_res.retired <= 1'b0;
                                    r_ca    <= rdata.target;
                                    r_cb    <= r_base;
                                    r_bramp <= rdata.out_ramp;
                                    r_state <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        for (int k = 0; k < 4; k++) begin
                            r_res.color[8*k +: 8] <= r_neg[k] ?
                                8'(r_ca[8*k +: 8] - div_q[k]) :
                                8'(r_ca[8*k +: 8] + div_q[k]);
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_h_valid || out_free) begin
                        if (r_h_valid) begin
                            r_out      <= r_hold;
                            r_out_last <= 1'b0;
                        end
                        r_hold    <= r_res;
                        r_h_valid <= 1'b1;
                        if (r_is_add) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_i <= i_nxt;
                            if (i_nxt == r_count) begin
                                r_count <= r_keep;
                                r_state <= S_FLUSH;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_h_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out      <= r_hold;
                        r_out_last <= 1'b1;
                        r_h_valid  <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // channel products for the blend
        if (r_state == S_MUL) begin
            for (int k = 0; k < 4; k++) begin
                if (r_cb[8*k +: 8] >= r_ca[8*k +: 8]) begin
                    d = {1'b0, r_cb[8*k +: 8]} - {1'b0, r_ca[8*k +: 8]};
                    r_neg[k] <= 1'b0;
                end else begin
                    d = {1'b0, r_ca[8*k +: 8]} - {1'b0, r_cb[8*k +: 8]};
                    r_neg[k] <= 1'b1;
                end
                r_num[k] <= 24'(d[7:0]) * 24'(r_bacc);
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_out.status;
    assign o_out_part  = r_out.part;
    assign o_color     = r_out.color;
    assign o_retired   = r_out.retired;
    assign o_last      = r_out_last;

endmodule

### tb/sv/color_fade_envelope_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_fade_envelope_table_tb
// Drives add and tick words into the fade table, predicts every color update
// and add status with a model of the entry table, and checks each result
// word against the oldest pending prediction, with random idling both sides.
// ----------------------------------------------------------------------------
module color_fade_envelope_table_tb
    import cfet_pkg::*;
();

    localparam int NSLOT = 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  part;
        logic [31:0] color;
        logic        retired;
        logic        last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic [2:0]  i_part = '0;
    logic        i_mode = 1'b0;
    logic [31:0] i_target_color = '0;
    logic [15:0] i_in_wait = '0, i_in_ramp = '0, i_out_wait = '0, i_out_ramp = '0;
    logic [15:0] i_delta_time = '0, i_anim_index = '0, i_anim_frame = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_out_part;
    logic [31:0] o_color;
    logic        o_retired;
    logic        o_last;

    color_fade_envelope_table i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    t_entry      fades [NSLOT];
    int          live_count;
    logic [31:0] base_rgba;
    t_word       pending_words [$];
    int          fail_count;
    int          cycles;
    logic [15:0] cur_aidx;
    logic [15:0] cur_frame;

    // per-channel linear blend, truncated toward zero
    function automatic logic [31:0] lerp_rgba(logic [31:0] a, logic [31:0] b,
                                              logic [15:0] acc, logic [15:0] ramp);
        logic [31:0] res;
        int unsigned ca, cb;
        res = '0;
        if (ramp == 0) return b;
        for (int k = 0; k < 4; k++) begin
            ca = a[8*k +: 8];
            cb = b[8*k +: 8];
            if (cb >= ca) res[8*k +: 8] = 8'(ca + ((cb - ca) * acc) / ramp);
            else res[8*k +: 8] = 8'(ca - ((ca - cb) * acc) / ramp);
        end
        return res;
    endfunction

    function automatic void push_word(logic [1:0] st, logic [2:0] p, logic [31:0] c,
                                      logic r);
        t_word w;
        w.status = st; w.part = p; w.color = c; w.retired = r; w.last = 1'b0;
        pending_words.insert(pending_words.size(), w);
    endfunction

    // work out the words caused by one accepted input word
    function automatic void predict_fades(logic kind, logic [2:0] part, logic mode,
        logic [31:0] tgt, logic [15:0] iw, logic [15:0] ir, logic [15:0] ow,
        logic [15:0] orp, logic [15:0] dt, logic [15:0] aidx, logic [15:0] afrm);
        int n0, keep;
        t_entry e;
        int unsigned sum;
        logic [15:0] pos;
        logic alive;
        n0 = pending_words.size();
        keep = 0;
        if (kind) begin
            if (live_count >= NSLOT) push_word(ST_FULL, part, '0, 1'b0);
            else begin
                e.part = part; e.mode = mode; e.target = tgt;
                e.in_wait = iw; e.in_ramp = ir; e.out_wait = ow; e.out_ramp = orp;
                e.phase = PH_WAIT_IN; e.acc = '0; e.aidx = aidx;
                fades[live_count] = e;
                live_count++;
                push_word(ST_ADDED, part, '0, 1'b0);
            end
        end else begin
            for (int i = 0; i < live_count; i++) begin
                e = fades[i];
                alive = 1'b1;
                if (e.mode && aidx != e.aidx) begin
                    push_word(ST_UPDATE, e.part, base_rgba, 1'b1);
                    continue;
                end
                sum = e.acc + dt;
                e.acc = (sum > 65535) ? 16'hFFFF : sum[15:0];
                case (e.phase)
                    PH_WAIT_IN: begin
                        pos = e.mode ? afrm : e.acc;
                        if (pos >= e.in_wait) begin
                            e.acc = '0; e.phase = PH_RAMP_IN;
                        end
                        push_word(ST_UPDATE, e.part, base_rgba, 1'b0);
                    end
                    PH_RAMP_IN: begin
                        if (e.acc >= e.in_ramp) begin
                            e.acc = '0; e.phase = PH_WAIT_OUT;
                            push_word(ST_UPDATE, e.part, e.target, 1'b0);
                        end else
                            push_word(ST_UPDATE, e.part,
                                lerp_rgba(base_rgba, e.target, e.acc, e.in_ramp), 1'b0);
                    end
                    PH_WAIT_OUT: begin
                        pos = e.mode ? afrm : e.acc;
                        if (pos >= e.out_wait) begin
                            e.acc = '0; e.phase = PH_RAMP_OUT;
                        end
                    end
                    default: begin
                        if (e.acc >= e.out_ramp) begin
                            push_word(ST_UPDATE, e.part, base_rgba, 1'b1);
                            alive = 1'b0;
                        end else
                            push_word(ST_UPDATE, e.part,
                                lerp_rgba(e.target, base_rgba, e.acc, e.out_ramp), 1'b0);
                    end
                endcase
                if (alive) begin
                    fades[keep] = e;
                    keep++;
                end
            end
            live_count = keep;
        end
        if (pending_words.size() > n0)
            pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // mostly short gaps, a few long ones, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result stall pattern, sampled values applied at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < 25) ||
                            ($urandom_range(0, 199) == 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_word got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = o_status; got.part = o_out_part; got.color = o_color;
            got.retired = o_retired; got.last = o_last;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word status=%0d part=%0d color=%h", $time,
                         o_status, o_out_part, o_color);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    fail_count++;
                end
                if (got.part !== want.part) begin
                    $display("%0t: part exp %0d got %0d", $time, want.part, got.part);
                    fail_count++;
                end
                if (got.color !== want.color) begin
                    $display("%0t: color exp %h got %h", $time, want.color, got.color);
                    fail_count++;
                end
                if (got.retired !== want.retired) begin
                    $display("%0t: retired exp %0d got %0d", $time, want.retired,
                             got.retired);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // send one word, holding it until accepted; valid drops only before a gap
    task automatic send_word(logic kind, logic [2:0] part, logic mode, logic [31:0] tgt,
        logic [15:0] iw, logic [15:0] ir, logic [15:0] ow, logic [15:0] orp,
        logic [15:0] dt, logic [15:0] aidx, logic [15:0] afrm);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind; i_part <= part; i_mode <= mode; i_target_color <= tgt;
        i_in_wait <= iw; i_in_ramp <= ir; i_out_wait <= ow; i_out_ramp <= orp;
        i_delta_time <= dt; i_anim_index <= aidx; i_anim_frame <= afrm;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_fades(kind, part, mode, tgt, iw, ir, ow, orp, dt, aidx, afrm);
    endtask

    task automatic add_fade(logic [2:0] part, logic mode, logic [31:0] tgt,
        logic [15:0] iw, logic [15:0] ir, logic [15:0] ow, logic [15:0] orp);
        send_word(1'b1, part, mode, tgt, iw, ir, ow, orp, 16'($urandom), cur_aidx,
                  16'($urandom));
    endtask

    task automatic tick(logic [15:0] dt);
        send_word(1'b0, 3'($urandom), 1'($urandom), $urandom, 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), dt, cur_aidx, cur_frame);
    endtask

    // stop sending, wait until every predicted word has come, then let the pipe drain
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_base(logic [31:0] value);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_BASE_COLOR, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        base_rgba = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // full table, zero-length ramps, time-mode envelope with extremes
    task automatic test_directed();
        write_base(32'h0000_0000);
        add_fade(3'd0, 1'b0, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        add_fade(3'd7, 1'b0, 32'h80FF_0040, 16'd5, 16'd100, 16'd3, 16'd50);
        add_fade(3'd1, 1'b0, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            add_fade(3'(i), 1'b1, $urandom, 16'd2, 16'd7, 16'd4, 16'd9);
        tick(16'd0);
        tick(16'd1);
        tick(16'd30);
        cur_frame = 16'hFFFF;
        tick(16'hFFFF);
        tick(16'hFFFF);
        cur_aidx = 16'h5A5A;
        tick(16'd2);
        tick(16'hFFFF);
        tick(16'd1);
        tick(16'd0);
        drain();
        write_base(32'hFFFF_FFFF);
        add_fade(3'd5, 1'b0, 32'h0000_0000, 16'd0, 16'd3, 16'd0, 16'd3);
        for (int i = 0; i < 6; i++) tick(16'd1);
    endtask

    // random envelopes, mostly short timings so entries cycle through all phases
    task automatic test_random(int count);
        int r;
        logic [15:0] t [4];
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                for (int k = 0; k < 4; k++)
                    t[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 40));
                add_fade(3'($urandom), 1'($urandom), $urandom, t[0], t[1], t[2], t[3]);
            end else begin
                if ($urandom_range(0, 19) == 0) cur_aidx = 16'($urandom);
                cur_frame = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                : 16'(cur_frame + $urandom_range(0, 3));
                tick(($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 12)));
            end
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        fail_count = 0;
        cycles = 0;
        live_count = 0;
        base_rgba = '0;
        cur_aidx = 16'h0001;
        cur_frame = 16'h0000;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(82);
        write_base($urandom);
        test_random(82);
        write_base(32'h00FF_00FF);
        test_random(82);
        drain();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
